/* hdl/b30flw_pkg.sv */
package b30flw_pkg;

  // Widths of the datapath.
  localparam int unsigned MagW  = 32;
  localparam int unsigned QuoW  = 28;
  localparam int unsigned DigW  = 5;
  localparam int unsigned NDig  = 8;
  localparam int unsigned IdxW  = $clog2(NDig);
  localparam int unsigned ColW  = 7;
  localparam int unsigned CharW = 8;
  localparam int unsigned ProdW = 64;

  // Division by 30 as a multiply by the rounded-up reciprocal 2^36 / 30.
  // The result is exact for every 32-bit dividend.
  localparam logic [MagW-1:0] Recip      = 32'h8888_8889;
  localparam int unsigned     RecipShift = 36;

  localparam logic [ColW-1:0] MinWidth   = 7'd9;
  localparam logic [ColW-1:0] WidthReset = 7'd80;

  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_Z     = 8'h5A;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_A     = 8'h41;

  typedef enum logic [1:0] {
    CMD_INT  = 2'd0,
    CMD_RAW  = 2'd1,
    CMD_PAD  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_FORCE_PLUS = 1'b1
  } reg_idx_t;

  // One character handed from the sequencer to the line stage.
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] code;
    logic             fin;
  } char_req_t;

  // Base-30 digit to its ASCII character: 0-9 then A-T.
  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d);
    logic [CharW-1:0] dw;
    dw = {{(CharW-DigW){1'b0}}, d};
    if (d < 5'd10) begin
      return CH_ZERO + dw;
    end else begin
      return CH_A + dw - 8'd10;
    end
  endfunction

endpackage

/* hdl/b30flw_divstep.sv */
module b30flw_divstep (
  input  logic                          clk,
  input  logic                          load,
  input  logic [b30flw_pkg::MagW-1:0]   dividend,
  output logic [b30flw_pkg::QuoW-1:0]   quo,
  output logic [b30flw_pkg::DigW-1:0]   rem
);
  import b30flw_pkg::*;

  logic [MagW-1:0]  dvd;
  logic [ProdW-1:0] prod;
  logic [MagW-1:0]  quo_ext;
  logic [MagW-1:0]  quo_x30;
  logic [MagW-1:0]  diff;

  // The product is registered; quotient and remainder are derived from it
  // combinationally in the cycle after the load.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd  <= dividend;
      prod <= {{(ProdW-MagW){1'b0}}, dividend} * {{(ProdW-MagW){1'b0}}, Recip};
    end
  end

  assign quo     = prod[RecipShift +: QuoW];
  assign quo_ext = {{(MagW-QuoW){1'b0}}, quo};
  assign quo_x30 = (quo_ext << 5) - (quo_ext << 1);
  assign diff    = dvd - quo_x30;
  assign rem     = diff[DigW-1:0];

endmodule

/* hdl/b30flw_line.sv */
module b30flw_line (
  input  logic                        clk,
  input  logic                        rst,
  input  b30flw_pkg::char_req_t       req,
  output logic                        req_ready,
  input  logic [b30flw_pkg::ColW-1:0] line_width,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,
  output logic                        m_tlast
);
  import b30flw_pkg::*;

  typedef enum logic [2:0] {
    P_NONE = 3'b001,
    P_CR   = 3'b010,
    P_LF   = 3'b100
  } pend_t;

  pend_t            pend;
  logic             pend_last;
  logic             ov;
  logic [CharW-1:0] o_char;
  logic [ColW-1:0]  o_col;
  logic             o_last;
  logic [ColW-1:0]  line_column;

  logic             advance;
  logic [ColW-1:0]  w_eff;
  logic [ColW:0]    col_sum;
  logic             wraps;

  assign advance   = !ov || m_tready;
  assign w_eff     = (line_width < MinWidth) ? MinWidth : line_width;
  assign col_sum   = {1'b0, line_column} + 8'd1;
  assign wraps     = col_sum >= {1'b0, w_eff};
  assign req_ready = advance && (pend == P_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov          <= 1'b0;
      pend        <= P_NONE;
      pend_last   <= 1'b0;
      line_column <= '0;
      o_char      <= '0;
      o_col       <= '0;
      o_last      <= 1'b0;
    end else if (advance) begin
      unique case (pend)
        P_CR: begin
          ov     <= 1'b1;
          o_char <= CH_CR;
          o_col  <= '0;
          o_last <= 1'b0;
          pend   <= P_LF;
        end
        P_LF: begin
          ov     <= 1'b1;
          o_char <= CH_LF;
          o_col  <= '0;
          o_last <= pend_last;
          pend   <= P_NONE;
        end
        P_NONE: begin
          if (req.valid) begin
            ov     <= 1'b1;
            o_char <= req.code;
            o_col  <= col_sum[ColW-1:0];
            if (wraps) begin
              o_last      <= 1'b0;
              pend        <= P_CR;
              pend_last   <= req.fin;
              line_column <= '0;
            end else begin
              o_last      <= req.fin;
              line_column <= col_sum[ColW-1:0];
            end
          end else begin
            ov <= 1'b0;
          end
        end
        default: begin
          pend <= P_NONE;
        end
      endcase
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {1'b0, o_col, o_char};
  assign m_tlast  = o_last;

endmodule

/* hdl/base30_field_line_writer.sv */
// Channel   Direction  Handshake                   Payload
// s_*       in         s_tvalid / s_tready         s_tdata, s_tuser (command)
// m_*       out        m_tvalid / m_tready         m_tdata, m_tlast (last char)
// cfg_*     in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// An integer word is captured, starts the divider, has its base-30 digits
// (up to seven) peeled off one at a time on the shared divide-by-30 unit,
// and leaves as characters (up to nine, plus CR LF) at the output register.
// A raw byte or pad word is captured and leaves as one character. Reset is
// synchronous and active high; it restores a line width of 80 with the plus
// sign off and the column at zero. A stalled m_tready holds the output
// register and, in turn, the sequencer; input is taken only when idle.
module base30_field_line_writer (
  input  logic        clk,
  input  logic        rst,
  // Input word.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value [31:0], data_byte [39:32]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  // Output character.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_char [7:0], column [14:8], zero [15]
  output logic        m_tlast,
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import b30flw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_CONV  = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_DIGIT = 7'b0010000,
    S_SLASH = 7'b0100000,
    S_ONE   = 7'b1000000
  } state_t;

  state_t           state;
  logic [ColW-1:0]  line_width;
  logic             force_plus;
  logic [MagW-1:0]  mag;
  logic             neg;
  logic [CharW-1:0] one_char;
  logic [DigW-1:0]  digs [NDig];
  logic [IdxW-1:0]  dcnt;

  logic [MagW-1:0]  s_value;
  logic [CharW-1:0] s_byte;
  cmd_t             s_cmd;
  logic             div_load;
  logic [MagW-1:0]  div_in;
  logic [QuoW-1:0]  quo;
  logic [DigW-1:0]  rem;
  logic             conv_more;
  char_req_t        req;
  logic             req_ready;

  assign s_value  = s_tdata[31:0];
  assign s_byte   = s_tdata[39:32];
  assign s_cmd    = cmd_t'(s_tuser);
  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // The divider peels off the least significant digit each cycle; the quotient
  // feeds straight back while it is nonzero and the digit store has room.
  assign conv_more = (quo != '0) && (dcnt != IdxW'(NDig - 1));
  assign div_load  = (state == S_LOAD) || ((state == S_CONV) && conv_more);
  assign div_in    = (state == S_LOAD) ? mag : {{(MagW-QuoW){1'b0}}, quo};

  b30flw_divstep u_divstep (
    .clk      (clk),
    .load     (div_load),
    .dividend (div_in),
    .quo      (quo),
    .rem      (rem)
  );

  // Character offered to the line stage in the current state.
  always_comb begin
    req.valid = 1'b0;
    req.code  = one_char;
    req.fin   = 1'b0;
    unique case (state)
      S_SIGN: begin
        req.valid = 1'b1;
        req.code  = neg ? CH_MINUS : CH_PLUS;
      end
      S_DIGIT: begin
        req.valid = 1'b1;
        req.code  = digit_char(digs[dcnt]);
      end
      S_SLASH: begin
        req.valid = 1'b1;
        req.code  = CH_SLASH;
        req.fin   = 1'b1;
      end
      S_ONE: begin
        req.valid = 1'b1;
        req.fin   = 1'b1;
      end
      default: begin
        req.valid = 1'b0;
      end
    endcase
  end

  b30flw_line u_line (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .req_ready  (req_ready),
    .line_width (line_width),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WidthReset;
      force_plus <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINE_WIDTH: line_width <= cfg_data;
        REG_FORCE_PLUS: force_plus <= cfg_data[0];
        default:        line_width <= line_width;
      endcase
    end
  end

  // Digit store: written at the conversion count, read back from the top.
  always_ff @(posedge clk) begin
    if (state == S_CONV) begin
      digs[dcnt] <= rem;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      dcnt     <= '0;
      neg      <= 1'b0;
      mag      <= '0;
      one_char <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            neg  <= s_value[MagW-1];
            mag  <= s_value[MagW-1] ? (32'd0 - s_value) : s_value;
            dcnt <= '0;
            unique case (s_cmd)
              CMD_INT: state <= S_LOAD;
              CMD_RAW: begin
                one_char <= s_byte;
                state    <= S_ONE;
              end
              CMD_PAD: begin
                one_char <= CH_Z;
                state    <= S_ONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          state <= S_CONV;
        end
        S_CONV: begin
          if (conv_more) begin
            dcnt <= dcnt + 3'd1;
          end else if (neg || force_plus) begin
            state <= S_SIGN;
          end else begin
            state <= S_DIGIT;
          end
        end
        S_SIGN: begin
          if (req_ready) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (req_ready) begin
            if (dcnt == '0) begin
              state <= S_SLASH;
            end else begin
              dcnt <= dcnt - 3'd1;
            end
          end
        end
        S_SLASH, S_ONE: begin
          if (req_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The divider must always leave a true base-30 remainder.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> (rem < 5'd30))
    else $error("divider remainder out of range");

  // Any 32-bit magnitude has at most seven base-30 digits.
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CONV) && (dcnt == 3'd6)) |-> (quo == '0))
    else $error("conversion ran past seven digits");

  // A taken line-break carriage return (the only CR at column zero) is
  // followed at once by the line feed.
  a_cr_lf: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && (m_tdata[7:0] == CH_CR) && (m_tdata[14:8] == 7'd0))
      |=> (m_tvalid && (m_tdata[7:0] == CH_LF) && (m_tdata[14:8] == 7'd0)))
    else $error("carriage return not followed by line feed");

  // Every data character counts itself, so only a line break reports
  // column zero.
  a_break_col: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[14:8] == 7'd0))
      |-> ((m_tdata[7:0] == CH_CR) || (m_tdata[7:0] == CH_LF)))
    else $error("column zero on a character that is not a line break");
`endif

endmodule

/* tb/base30_field_line_writer_test.sv */
`timescale 1ns / 1ps

module base30_field_line_writer_test;
  import b30flw_pkg::*;

  localparam int HalfPeriod = 6;
  // An integer word needs a capture, a divider start, up to seven digits and
  // up to eleven characters. The settle wait is rounded up from that for the
  // quiet time before a register write and at the end of the run.
  localparam int SettleCycles = 24;
  // About 210 words, each with up to 11 characters. Each character may wait
  // through a heavy receiver stall and each word through a sender gap. Even
  // with all of that, the limit leaves a wide margin.
  localparam int CycleLimit = 400000;
  localparam int RandomPhases = 4;
  localparam int WordsPerPhase = 45;
  localparam int PlanRows = 27;

  // One expected output character with its line position.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic [6:0] col;
  } glyph_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  // One row of the directed plan. Either an input word or a register write.
  // A row with 'typed' set carries its character sequence spelled out.
  typedef struct {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [31:0] value;
    logic [7:0]  data_byte;
    reg_idx_t    reg_sel;
    logic [6:0]  reg_val;
    bit          typed;
    string       spelled;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // value [31:0], data_byte [39:32]
  logic [1:0]  s_tuser = '0;    // cmd [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // out_char [7:0], column [14:8], zero [15]
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  base30_field_line_writer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  // The directed plan. It starts with the reset settings, where the spelled
  // text of a word is obvious. Then it uses the narrowest width with the plus
  // sign on. Then it writes into a wide line and drops the width below the current
  // column, so the next character has to close the line at once.
  plan_row_t plan [PlanRows] = '{
    '{ROW_WORD, CMD_INT,  32'h0000_0000, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b1, "0/"},
    '{ROW_WORD, CMD_INT,  32'd29,        8'hFF, REG_LINE_WIDTH, 7'd0,   1'b1, "T/"},
    '{ROW_WORD, CMD_INT,  32'd30,        8'h00, REG_LINE_WIDTH, 7'd0,   1'b1, "10/"},
    '{ROW_WORD, CMD_INT,  32'hFFFF_FFFF, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b1, "-1/"},
    '{ROW_WORD, CMD_INT,  32'h7FFF_FFFF, 8'hFF, REG_LINE_WIDTH, 7'd0,   1'b1, "2SB6CS7/"},
    '{ROW_WORD, CMD_INT,  32'h8000_0000, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b1, "-2SB6CS8/"},
    '{ROW_WORD, CMD_RAW,  32'hFFFF_FFFF, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_RAW,  32'h0000_0000, 8'hFF, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_PAD,  32'hFFFF_FFFF, 8'hFF, REG_LINE_WIDTH, 7'd0,   1'b1, "Z"},
    '{ROW_WORD, CMD_NONE, 32'h1234_5678, 8'hC3, REG_LINE_WIDTH, 7'd0,   1'b1, ""},
    '{ROW_REG,  CMD_NONE, 32'h0,         8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_REG,  CMD_NONE, 32'h0,         8'h00, REG_FORCE_PLUS, 7'd1,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'd5,         8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'd123456789, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'd0,         8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'hFFFF_FFF9, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_RAW,  32'h0,         8'hA5, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_PAD,  32'h0,         8'h5A, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_REG,  CMD_NONE, 32'h0,         8'h00, REG_LINE_WIDTH, 7'd127, 1'b0, ""},
    '{ROW_REG,  CMD_NONE, 32'h0,         8'h00, REG_FORCE_PLUS, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'h8000_0000, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'h8000_0000, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'h8000_0000, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'h7FFF_FFFF, 8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_REG,  CMD_NONE, 32'h0,         8'h00, REG_LINE_WIDTH, 7'd10,  1'b0, ""},
    '{ROW_WORD, CMD_PAD,  32'h0,         8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""},
    '{ROW_WORD, CMD_INT,  32'h0,         8'h00, REG_LINE_WIDTH, 7'd0,   1'b0, ""}
  };

  // Copy of the block's settings and line position.
  logic [6:0] line_width_now = WidthReset;
  bit         plus_now = 1'b0;
  logic [6:0] column_now = '0;

  string      b30_glyphs = "0123456789ABCDEFGHIJKLMNOPQRST";
  logic [7:0] word_text[$];   // characters of one word before line wrapping
  glyph_t     line_chars[$];  // characters the block still owes us, oldest first

  int  mismatches = 0;
  int  cycles = 0;
  bit  tx_live = 1'b0;
  bit  cfg_live = 1'b0;
  int  burst_left = 0;

  // Spells one input word as text: the sign, the base-30 digits with the most
  // significant first, and the slash. A raw byte or a pad is one character.
  // The unused command produces no text.
  function automatic void spell_word(input cmd_t c, input logic [31:0] v,
                                     input logic [7:0] b);
    logic [31:0] mag;
    logic [4:0]  digs [8];
    int          n;
    word_text.delete();
    n = 0;
    case (c)
      CMD_INT: begin
        // Negating the most negative value gives 2^31 again. Read as
        // unsigned, that is the correct magnitude.
        mag = v[31] ? -v : v;
        if (v[31]) begin
          word_text.push_back(CH_MINUS);
        end else if (plus_now) begin
          word_text.push_back(CH_PLUS);
        end
        do begin
          digs[n] = 5'(mag % 32'd30);
          mag = mag / 32'd30;
          n++;
        end while (mag != 0);
        for (int i = n - 1; i >= 0; i--) word_text.push_back(b30_glyphs[digs[i]]);
        word_text.push_back(CH_SLASH);
      end
      CMD_RAW: word_text.push_back(b);
      CMD_PAD: word_text.push_back(CH_Z);
      default: ;
    endcase
  endfunction

  // Places the spelled word on the line. The line closes on the character
  // that reaches the width. That character reports the full count, and the
  // CR LF after it reports zero. A width below nine counts as nine. A column
  // already past a newly lowered width closes the line on the next character.
  function automatic void wrap_into_line();
    logic [6:0] eff;
    logic [6:0] col;
    logic       fin;
    eff = (line_width_now < MinWidth) ? MinWidth : line_width_now;
    foreach (word_text[i]) begin
      col = column_now + 7'd1;
      fin = (i == word_text.size() - 1);
      if (col >= eff) begin
        line_chars.push_back(glyph_t'{word_text[i], 1'b0, col});
        line_chars.push_back(glyph_t'{CH_CR, 1'b0, 7'd0});
        line_chars.push_back(glyph_t'{CH_LF, fin, 7'd0});
        column_now = '0;
      end else begin
        line_chars.push_back(glyph_t'{word_text[i], fin, col});
        column_now = col;
      end
    end
  endfunction

  task automatic drop_word_valid();
    if (tx_live) begin
      s_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
  endtask

  // Offers one word and holds it until it is taken. Then, if the current
  // burst is used up, the sender goes quiet for a random gap. Any register
  // write still offered is withdrawn in the same step, so it does not repeat.
  task automatic send_word(input cmd_t c, input logic [31:0] v, input logic [7:0] b,
                           input bit typed, input string spelled);
    if (cfg_live) begin
      cfg_valid <= 1'b0;
      cfg_live = 1'b0;
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {b, v};
    tx_live = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (typed) begin
      word_text.delete();
      for (int i = 0; i < spelled.len(); i++) word_text.push_back(spelled[i]);
    end else begin
      spell_word(c, v, b);
    end
    wrap_into_line();
    burst_left--;
    if (burst_left <= 0) begin
      drop_word_valid();
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 14);
    end
  endtask

  // Back-to-back writes keep valid high. The next word lowers it.
  task automatic write_reg(input reg_idx_t sel, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    cfg_live = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (sel == REG_LINE_WIDTH) begin
      line_width_now = val;
    end else begin
      plus_now = val[0];
    end
  endtask

  // Holds the sender back until every owed character has come out.
  task automatic drain_line();
    drop_word_valid();
    do @(posedge clk); while (line_chars.size() != 0);
  endtask

  // A word of the unused command owes nothing, and the block does not leave
  // idle for it. A register write still waits out the block's latency.
  task automatic settle_for_regs();
    drain_line();
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic cmd_t pick_cmd();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) begin
      return CMD_INT;
    end else if (r < 15) begin
      return CMD_RAW;
    end else if (r < 19) begin
      return CMD_PAD;
    end else begin
      return CMD_NONE;
    end
  endfunction

  // Favors the extremes and short numbers. The rest is spread over the full
  // 32-bit range, so every bit of the value field toggles.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(0, 899));
      4: return -32'($urandom_range(1, 899));
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    int         words;
    cmd_t       c;
    logic [6:0] width_pick;
    bit         plus_pick;
    bit         prev_word;
    prev_word = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A register row that follows a word first waits until
    // the block is idle.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (prev_word) settle_for_regs();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
        prev_word = 1'b0;
      end else begin
        send_word(plan[i].cmd, plan[i].value, plan[i].data_byte,
                  plan[i].typed, plan[i].spelled);
        prev_word = 1'b1;
      end
    end

    // Random part. Each phase uses its own line width and sign setting: the
    // narrowest width, the widest, a width just above the floor, and a random
    // one. A narrow phase that follows the wide one usually starts with the
    // column already past the new width.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: begin
          width_pick = 7'd1;
          plus_pick = 1'b0;
        end
        1: begin
          width_pick = 7'd127;
          plus_pick = 1'b1;
        end
        2: begin
          width_pick = 7'd10;
          plus_pick = 1'($urandom_range(0, 1));
        end
        default: begin
          width_pick = 7'($urandom_range(0, 127));
          plus_pick = 1'($urandom_range(0, 1));
        end
      endcase
      settle_for_regs();
      write_reg(REG_LINE_WIDTH, width_pick);
      write_reg(REG_FORCE_PLUS, 7'(plus_pick));
      words = 0;
      while (words < WordsPerPhase) begin
        c = pick_cmd();
        send_word(c, pick_value(), 8'($urandom), 1'b0, "");
        if (c != CMD_NONE) words++;
        if ($urandom_range(0, 39) == 0) drain_line();
      end
    end

    drain_line();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && line_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver. It checks each word it takes against the oldest owed character.
  // m_tready follows a mode drawn at random from four: always ready, a coin
  // flip, ready a quarter of the time, or a heavy stall.
  int rx_mode = 0;
  int rx_count = 0;

  always @(posedge clk) begin : receiver
    glyph_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (line_chars.size() == 0) begin
        $error("character word with none expected: out_char %h column %0d",
               m_tdata[7:0], m_tdata[14:8]);
        mismatches++;
      end else begin
        want = line_chars.pop_front();
        if (m_tdata[7:0] !== want.ch) begin
          $error("out_char: expected %h, actual %h", want.ch, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[14:8] !== want.col) begin
          $error("column: expected %0d, actual %0d", want.col, m_tdata[14:8]);
          mismatches++;
        end
        if (m_tlast !== want.fin) begin
          $error("last: expected %b, actual %b", want.fin, m_tlast);
          mismatches++;
        end
        if (m_tdata[15] !== 1'b0) begin
          $error("tdata fill bit: expected 0, actual %b", m_tdata[15]);
          mismatches++;
        end
      end
    end
    rx_count++;
    if (rx_count % 48 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (rx_count % 4 == 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

/* base30_field_line_writer.f */
hdl/b30flw_pkg.sv
hdl/b30flw_divstep.sv
hdl/b30flw_line.sv
hdl/base30_field_line_writer.sv
tb/base30_field_line_writer_test.sv
